@@ hw/rtl/lfu_pkg.sv @@
// Package for the LFU replacement table: shared constants, controller state
// encoding and the command/status structs between controller and datapath.
// No dependencies.
`default_nettype none

package lfu_pkg;

	// Default sizes of the table and its fields
	localparam int NUM_ENTRIES_DEF = 16;
	localparam int KEY_BITS_DEF    = 32;
	localparam int COUNT_BITS_DEF  = 16;
	localparam int STAMP_BITS_DEF  = 32;

	// Configuration register file
	localparam int          CFG_W              = 5;
	localparam int          APB_DATA_W         = 32;
	localparam int          APB_ADDR_W         = 3;
	localparam logic        REG_ACTIVE_ENTRIES = 1'b0;
	localparam logic [4:0]  ACTIVE_RESET       = 5'd16;

	// Controller states
	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SCAN,
		ST_DRAIN,
		ST_UPDATE
	} lfu_state_t;

	// Controller to datapath
	typedef struct packed {
		logic load;     // latch request key, clear scan trackers
		logic scan_en;  // read one entry, advance scan pointer
		logic update;   // commit table write and result
	} lfu_cmd_t;

	// Datapath to controller
	typedef struct packed {
		logic scan_last; // scan pointer on the last entry
	} lfu_status_t;

endpackage

`default_nettype wire

@@ hw/rtl/lfu_ctrl.sv @@
// Controller of the LFU replacement table: sequences load, entry scan,
// drain of the read stage and table update.
// Depends on lfu_pkg.
`default_nettype none

module lfu_ctrl import lfu_pkg::*; (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        start,
	input  wire lfu_status_t status,
	output lfu_cmd_t         cmd,
	output logic             busy
);

	lfu_state_t state_q, state_nxt;

	// State register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_nxt;
		end
	end

	// Next state
	always_comb begin
		state_nxt = state_q;
		case (state_q)
			ST_IDLE: begin
				if (start) state_nxt = ST_SCAN;
			end
			ST_SCAN: begin
				if (status.scan_last) state_nxt = ST_DRAIN;
			end
			ST_DRAIN:  state_nxt = ST_UPDATE;
			ST_UPDATE: state_nxt = ST_IDLE;
			default:   state_nxt = ST_IDLE;
		endcase
	end

	// Outputs
	always_comb begin
		cmd  = '0;
		busy = 1'b1;
		case (state_q)
			ST_IDLE: begin
				busy     = 1'b0;
				cmd.load = start;
			end
			ST_SCAN:   cmd.scan_en = 1'b1;
			ST_DRAIN:  cmd = '0;
			ST_UPDATE: cmd.update = 1'b1;
			default:   busy = 1'b0;
		endcase
	end

endmodule

`default_nettype wire

@@ hw/rtl/lfu_datapath.sv @@
// Datapath of the LFU replacement table: entry memories, valid bits,
// scan trackers for match, free slot and victim, and the result register.
// Depends on lfu_pkg.
`default_nettype none

module lfu_datapath import lfu_pkg::*; #(
	parameter int NUM_ENTRIES = NUM_ENTRIES_DEF,
	parameter int KEY_BITS    = KEY_BITS_DEF,
	parameter int COUNT_BITS  = COUNT_BITS_DEF,
	parameter int STAMP_BITS  = STAMP_BITS_DEF,
	localparam int IDX_W      = $clog2(NUM_ENTRIES),
	localparam int FILL_W     = $clog2(NUM_ENTRIES + 1)
) (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire lfu_cmd_t              cmd,
	output lfu_status_t                status,
	input  wire logic [CFG_W-1:0]      active_entries,
	input  wire logic [KEY_BITS-1:0]   access_key,
	output logic                       done,
	output logic                       hit,
	output logic                       evicted,
	output logic [KEY_BITS-1:0]        evicted_key,
	output logic [IDX_W-1:0]           slot_index,
	output logic [COUNT_BITS-1:0]      use_count,
	output logic                       stamp_overflow
);

	localparam logic [COUNT_BITS-1:0] COUNT_MAX = {COUNT_BITS{1'b1}};
	localparam logic [STAMP_BITS-1:0] STAMP_MAX = {STAMP_BITS{1'b1}};
	localparam logic [IDX_W-1:0]      LAST_IDX  = IDX_W'(NUM_ENTRIES - 1);

	// Entry storage
	logic [KEY_BITS-1:0]   mem_key   [NUM_ENTRIES];
	logic [COUNT_BITS-1:0] mem_cnt   [NUM_ENTRIES];
	logic [STAMP_BITS-1:0] mem_stamp [NUM_ENTRIES];
	logic [NUM_ENTRIES-1:0] valid_q;

	logic [FILL_W-1:0]     filled_q;
	logic [STAMP_BITS-1:0] stamp_q;
	logic [KEY_BITS-1:0]   key_q;
	logic [IDX_W-1:0]      scan_q;

	// Read stage
	logic                  rd_vld_s1;
	logic                  rd_valid_s1;
	logic [IDX_W-1:0]      rd_idx_s1;
	logic [KEY_BITS-1:0]   rd_key_s1;
	logic [COUNT_BITS-1:0] rd_cnt_s1;
	logic [STAMP_BITS-1:0] rd_stamp_s1;

	// Trackers
	logic                  found_q, have_free_q, have_best_q;
	logic [IDX_W-1:0]      match_idx_q, free_idx_q, best_idx_q;
	logic [COUNT_BITS-1:0] match_cnt_q, best_cnt_q;
	logic [STAMP_BITS-1:0] best_stamp_q;
	logic [KEY_BITS-1:0]   best_key_q;

	logic is_match, is_free, is_better;

	// Update decision
	logic [FILL_W-1:0]     cap;
	logic                  room;
	logic [IDX_W-1:0]      wr_slot;
	logic [COUNT_BITS-1:0] wr_cnt;
	logic [STAMP_BITS-1:0] stamp_nxt;

	assign status.scan_last = (scan_q == LAST_IDX);

	// Request key and scan pointer
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			key_q  <= access_key;
			scan_q <= '0;
		end else if (cmd.scan_en) begin
			scan_q <= scan_q + 1'b1;
		end
	end

	// Entry read, one per scan cycle
	always_ff @(posedge clk) begin
		if (cmd.scan_en) begin
			rd_key_s1   <= mem_key[scan_q];
			rd_cnt_s1   <= mem_cnt[scan_q];
			rd_stamp_s1 <= mem_stamp[scan_q];
			rd_valid_s1 <= valid_q[scan_q];
			rd_idx_s1   <= scan_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rd_vld_s1 <= 1'b0;
		end else begin
			rd_vld_s1 <= cmd.scan_en;
		end
	end

	// Compare of the entry just read
	assign is_match  = rd_vld_s1 && rd_valid_s1 && (rd_key_s1 == key_q) && !found_q;
	assign is_free   = rd_vld_s1 && !rd_valid_s1 && !have_free_q;
	assign is_better = rd_vld_s1 && rd_valid_s1 &&
		(!have_best_q || (rd_cnt_s1 < best_cnt_q) ||
		 ((rd_cnt_s1 == best_cnt_q) && (rd_stamp_s1 > best_stamp_q)));

	// Scan tracker flags
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			found_q     <= 1'b0;
			have_free_q <= 1'b0;
			have_best_q <= 1'b0;
		end else if (cmd.load) begin
			found_q     <= 1'b0;
			have_free_q <= 1'b0;
			have_best_q <= 1'b0;
		end else begin
			if (is_match)  found_q     <= 1'b1;
			if (is_free)   have_free_q <= 1'b1;
			if (is_better) have_best_q <= 1'b1;
		end
	end

	// Scan tracker payload
	always_ff @(posedge clk) begin
		if (is_match) begin
			match_idx_q <= rd_idx_s1;
			match_cnt_q <= rd_cnt_s1;
		end
		if (is_free) begin
			free_idx_q <= rd_idx_s1;
		end
		if (is_better) begin
			best_idx_q   <= rd_idx_s1;
			best_cnt_q   <= rd_cnt_s1;
			best_stamp_q <= rd_stamp_s1;
			best_key_q   <= rd_key_s1;
		end
	end

	// Capacity clamped to 1..NUM_ENTRIES
	always_comb begin
		if (active_entries == '0) begin
			cap = FILL_W'(1);
		end else if (32'(active_entries) > 32'(NUM_ENTRIES)) begin
			cap = FILL_W'(NUM_ENTRIES);
		end else begin
			cap = FILL_W'(active_entries);
		end
	end

	// Slot, count and next stamp for this request
	always_comb begin
		room = (filled_q < cap);
		if (found_q) begin
			wr_slot = match_idx_q;
			wr_cnt  = (match_cnt_q == COUNT_MAX) ? match_cnt_q : match_cnt_q + 1'b1;
		end else begin
			wr_slot = room ? free_idx_q : best_idx_q;
			wr_cnt  = COUNT_BITS'(1);
		end
		stamp_nxt = (stamp_q == STAMP_MAX) ? stamp_q : stamp_q + 1'b1;
	end

	// Entry write
	always_ff @(posedge clk) begin
		if (cmd.update) begin
			mem_key[wr_slot]   <= key_q;
			mem_cnt[wr_slot]   <= wr_cnt;
			mem_stamp[wr_slot] <= stamp_q;
		end
	end

	// Valid bits, fill count, stamp counter
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q  <= '0;
			filled_q <= '0;
			stamp_q  <= '0;
		end else if (cmd.update) begin
			valid_q[wr_slot] <= 1'b1;
			stamp_q          <= stamp_nxt;
			if (!found_q && room) filled_q <= filled_q + 1'b1;
		end
	end

	// Result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done <= 1'b0;
		end else begin
			done <= cmd.update;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.update) begin
			hit            <= found_q;
			evicted        <= !found_q && !room;
			evicted_key    <= (!found_q && !room) ? best_key_q : '0;
			slot_index     <= wr_slot;
			use_count      <= wr_cnt;
			stamp_overflow <= (stamp_nxt == STAMP_MAX);
		end
	end

endmodule

`default_nettype wire

@@ hw/rtl/lfu_replacement_table.sv @@
// Top level of the LFU replacement table: configuration register port,
// controller and datapath. Depends on lfu_pkg, lfu_ctrl, lfu_datapath.
//
// A request is taken when start is high while busy is low. The table is
// scanned one entry per cycle through a single read port of the entry
// memories, so busy stays high through the scan, the read-stage drain and
// the update. The result appears on the result ports with done high for
// exactly one cycle, registered from the update state. busy is already low
// in that cycle, so a new request may be taken at the edge that ends it.
// A new request is never taken before the last one has its result.
// Results cannot be held off: the receiver must take them in the cycle done
// is high.
// active_entries (byte address 0) sets the capacity; write it only while
// busy is low and no result is pending.
`default_nettype none

module lfu_replacement_table import lfu_pkg::*; #(
	parameter int NUM_ENTRIES = NUM_ENTRIES_DEF,
	parameter int KEY_BITS    = KEY_BITS_DEF,
	parameter int COUNT_BITS  = COUNT_BITS_DEF,
	parameter int STAMP_BITS  = STAMP_BITS_DEF,
	localparam int IDX_W      = $clog2(NUM_ENTRIES)
) (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	// configuration port
	input  wire logic                  psel,
	input  wire logic                  penable,
	input  wire logic                  pwrite,
	input  wire logic [APB_ADDR_W-1:0] paddr,
	input  wire logic [APB_DATA_W-1:0] pwdata,
	output logic [APB_DATA_W-1:0]      prdata,
	output logic                       pready,
	// request
	input  wire logic                  start,
	output logic                       busy,
	input  wire logic [KEY_BITS-1:0]   access_key,
	// result
	output logic                       done,
	output logic                       hit,
	output logic                       evicted,
	output logic [KEY_BITS-1:0]        evicted_key,
	output logic [IDX_W-1:0]           slot_index,
	output logic [COUNT_BITS-1:0]      use_count,
	output logic                       stamp_overflow
);

	logic [CFG_W-1:0] active_q;
	logic             reg_sel;
	lfu_cmd_t         cmd;
	lfu_status_t      status;

	// Register decode on word address
	assign reg_sel = (paddr[2] == REG_ACTIVE_ENTRIES);
	assign pready  = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_q <= ACTIVE_RESET;
		end else if (psel && penable && pwrite && pready && reg_sel) begin
			active_q <= pwdata[CFG_W-1:0];
		end
	end

	assign prdata = reg_sel ? APB_DATA_W'(active_q) : '0;

	lfu_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.status (status),
		.cmd    (cmd),
		.busy   (busy)
	);

	lfu_datapath #(
		.NUM_ENTRIES (NUM_ENTRIES),
		.KEY_BITS    (KEY_BITS),
		.COUNT_BITS  (COUNT_BITS),
		.STAMP_BITS  (STAMP_BITS)
	) u_datapath (
		.clk            (clk),
		.arst_n         (arst_n),
		.cmd            (cmd),
		.status         (status),
		.active_entries (active_q),
		.access_key     (access_key),
		.done           (done),
		.hit            (hit),
		.evicted        (evicted),
		.evicted_key    (evicted_key),
		.slot_index     (slot_index),
		.use_count      (use_count),
		.stamp_overflow (stamp_overflow)
	);

	// Checks
	a_req_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |=> busy)
		else $error("request taken but busy not raised");

	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> (!busy && $past(busy)))
		else $error("result strobe outside end of request");

	a_hit_evict: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> !(hit && evicted))
		else $error("hit and eviction in one result");

	a_evkey_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(done && !evicted) |-> (evicted_key == '0))
		else $error("evicted key nonzero without eviction");

endmodule

`default_nettype wire

@@ verif/lfu_checker.sv @@
`timescale 1ns / 1ps
// Checker for the LFU replacement table: tracks capacity writes and accepted
// requests, predicts each lookup result and compares it with the done strobe.
// Depends on lfu_pkg.
module lfu_checker import lfu_pkg::*; (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      psel,
	input  logic                      penable,
	input  logic                      pwrite,
	input  logic                      pready,
	input  logic [APB_ADDR_W-1:0]     paddr,
	input  logic [APB_DATA_W-1:0]     pwdata,
	input  logic                      start,
	input  logic                      busy,
	input  logic [KEY_BITS_DEF-1:0]   access_key,
	input  logic                      done,
	input  logic                      hit,
	input  logic                      evicted,
	input  logic [KEY_BITS_DEF-1:0]   evicted_key,
	input  logic [$clog2(NUM_ENTRIES_DEF)-1:0] slot_index,
	input  logic [COUNT_BITS_DEF-1:0] use_count,
	input  logic                      stamp_overflow,
	output int                        mismatch_count,
	output int                        lookups_in_flight
);

	localparam int SLOT_W = $clog2(NUM_ENTRIES_DEF);

	typedef struct packed {
		logic                      hit;
		logic                      evicted;
		logic [KEY_BITS_DEF-1:0]   evicted_key;
		logic [SLOT_W-1:0]         slot;
		logic [COUNT_BITS_DEF-1:0] count;
		logic                      stamp_sat;
	} lookup_result_t;

	// shadow copy of the table
	logic                      tbl_valid [NUM_ENTRIES_DEF];
	logic [KEY_BITS_DEF-1:0]   tbl_key   [NUM_ENTRIES_DEF];
	logic [COUNT_BITS_DEF-1:0] tbl_count [NUM_ENTRIES_DEF];
	logic [STAMP_BITS_DEF-1:0] tbl_stamp [NUM_ENTRIES_DEF];
	int                        tbl_filled;
	logic [STAMP_BITS_DEF-1:0] next_stamp;
	logic [CFG_W-1:0]          capacity_reg;

	lookup_result_t pending_lookups [$];

	initial mismatch_count = 0;

	// hand out a placement stamp; the counter sticks at all ones
	function automatic logic [STAMP_BITS_DEF-1:0] take_stamp();
		logic [STAMP_BITS_DEF-1:0] s;
		s = next_stamp;
		if (next_stamp != '1)
			next_stamp = next_stamp + 1'b1;
		return s;
	endfunction

	// one table access: hit, fill a free slot, or replace the LFU victim
	function automatic lookup_result_t predict_access(input logic [KEY_BITS_DEF-1:0] key);
		lookup_result_t r;
		int slot;
		int cap;
		bit found;
		bit have;
		r = '0;
		slot = 0;
		found = 1'b0;
		have = 1'b0;
		cap = (capacity_reg == 0) ? 1 :
			(capacity_reg > NUM_ENTRIES_DEF) ? NUM_ENTRIES_DEF : int'(capacity_reg);
		for (int i = 0; i < NUM_ENTRIES_DEF; i++) begin
			if (!found && tbl_valid[i] && tbl_key[i] == key) begin
				slot = i;
				found = 1'b1;
			end
		end
		if (found) begin
			r.hit = 1'b1;
			if (tbl_count[slot] != '1)
				tbl_count[slot] = tbl_count[slot] + 1'b1;
			tbl_stamp[slot] = take_stamp();
		end else begin
			if (tbl_filled < cap) begin
				// lowest free slot
				for (int i = NUM_ENTRIES_DEF - 1; i >= 0; i--)
					if (!tbl_valid[i])
						slot = i;
				tbl_filled++;
			end else begin
				// lowest count, then newest stamp, then lowest slot
				for (int i = 0; i < NUM_ENTRIES_DEF; i++) begin
					if (tbl_valid[i] && (!have || tbl_count[i] < tbl_count[slot] ||
						(tbl_count[i] == tbl_count[slot] &&
						 tbl_stamp[i] > tbl_stamp[slot]))) begin
						slot = i;
						have = 1'b1;
					end
				end
				r.evicted = 1'b1;
				r.evicted_key = tbl_key[slot];
			end
			tbl_valid[slot] = 1'b1;
			tbl_key[slot] = key;
			tbl_count[slot] = 1;
			tbl_stamp[slot] = take_stamp();
		end
		r.slot = slot[SLOT_W-1:0];
		r.count = tbl_count[slot];
		r.stamp_sat = (next_stamp == '1);
		return r;
	endfunction

	task automatic check_field(input string field, input logic [KEY_BITS_DEF-1:0] want,
		input logic [KEY_BITS_DEF-1:0] got);
		if (got !== want) begin
			mismatch_count++;
			$display("%0t: %s mismatch, expected %h actual %h", $time, field, want, got);
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		lookup_result_t exp_res;
		if (!arst_n) begin
			for (int i = 0; i < NUM_ENTRIES_DEF; i++) begin
				tbl_valid[i] = 1'b0;
				tbl_key[i] = '0;
				tbl_count[i] = '0;
				tbl_stamp[i] = '0;
			end
			tbl_filled = 0;
			next_stamp = '0;
			capacity_reg = ACTIVE_RESET;
			pending_lookups.delete();
			lookups_in_flight <= 0;
		end else begin
			// capacity register write
			if (psel && penable && pwrite && pready &&
				paddr[APB_ADDR_W-1:2] == REG_ACTIVE_ENTRIES)
				capacity_reg = pwdata[CFG_W-1:0];

			// result strobe against the oldest prediction
			if (done) begin
				if (pending_lookups.size() == 0) begin
					mismatch_count++;
					$display("%0t: result with no request outstanding, expected none actual key %h",
						$time, evicted_key);
				end else begin
					exp_res = pending_lookups.pop_front();
					check_field("hit", exp_res.hit, hit);
					check_field("evicted", exp_res.evicted, evicted);
					check_field("evicted_key", exp_res.evicted_key, evicted_key);
					check_field("slot_index", exp_res.slot, slot_index);
					check_field("use_count", exp_res.count, use_count);
					check_field("stamp_overflow", exp_res.stamp_sat, stamp_overflow);
				end
			end

			// accepted request
			if (start && !busy)
				pending_lookups.push_back(predict_access(access_key));

			lookups_in_flight <= pending_lookups.size();
		end
	end

endmodule

@@ verif/tb_lfu_replacement_table.sv @@
`timescale 1ns / 1ps
// Testbench top for the LFU replacement table: clock, reset, request and
// capacity-register stimulus, and the verdict. Depends on lfu_pkg, the
// lfu_replacement_table RTL and lfu_checker.
module tb_lfu_replacement_table;
	import lfu_pkg::*;

	localparam int                  SLOT_W        = $clog2(NUM_ENTRIES_DEF);
	localparam logic [APB_ADDR_W-1:0] ADDR_ACTIVE   = {REG_ACTIVE_ENTRIES, 2'b00};
	localparam logic [APB_ADDR_W-1:0] ADDR_UNMAPPED = 3'd4;
	localparam int                  RANDOM_PHASES = 9;
	localparam int                  PHASE_ITEMS   = 150;

	logic                      clk = 1'b0;
	logic                      arst_n = 1'b0;
	logic                      psel = 1'b0;
	logic                      penable = 1'b0;
	logic                      pwrite = 1'b0;
	logic [APB_ADDR_W-1:0]     paddr = '0;
	logic [APB_DATA_W-1:0]     pwdata = '0;
	logic [APB_DATA_W-1:0]     prdata;
	logic                      pready;
	logic                      start = 1'b0;
	logic                      busy;
	logic [KEY_BITS_DEF-1:0]   access_key = '0;
	logic                      done;
	logic                      hit;
	logic                      evicted;
	logic [KEY_BITS_DEF-1:0]   evicted_key;
	logic [SLOT_W-1:0]         slot_index;
	logic [COUNT_BITS_DEF-1:0] use_count;
	logic                      stamp_overflow;
	int                        mismatch_count;
	int                        lookups_in_flight;

	lfu_replacement_table dut (.*);

	lfu_checker u_checker (.*);

	initial begin
		forever #2 clk = ~clk;
	end

	// run limit
	initial begin
		#2_000_000;
		$display("tb: failure");
		$finish;
	end

	// hold the request until the table takes it
	task automatic issue_access(input logic [KEY_BITS_DEF-1:0] key);
		start <= 1'b1;
		access_key <= key;
		@(posedge clk);
		while (busy)
			@(posedge clk);
	endtask

	// stop requesting and wait for every result to come back
	task automatic drain_table();
		start <= 1'b0;
		do
			@(posedge clk);
		while (lookups_in_flight != 0);
	endtask

	// setup and access phase, then return to idle
	task automatic apb_write(input logic [APB_ADDR_W-1:0] addr,
		input logic [APB_DATA_W-1:0] data);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= addr;
		pwdata <= data;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		@(posedge clk);
	endtask

	initial begin
		logic [KEY_BITS_DEF-1:0] key_pool [$];
		logic [KEY_BITS_DEF-1:0] key;
		logic [CFG_W-1:0] phase_caps [RANDOM_PHASES];
		int idle_pct;
		int eff_cap;
		int pick;

		phase_caps = '{5'd16, 5'd1, 5'd4, 5'd0, 5'd9, 5'd31, 5'd2, 5'd16, 5'd7};

		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: key extremes, hits, fills at reset capacity
		issue_access('0);
		issue_access('1);
		issue_access('0);
		issue_access('0);
		issue_access(32'h8000_0000);
		issue_access(32'h5555_5555);
		issue_access(32'hAAAA_AAAA);
		drain_table();

		// capacity lowered below the filled count: every miss evicts
		apb_write(ADDR_ACTIVE, 32'd3);
		issue_access(32'h0000_0001);
		issue_access(32'h0000_0002);
		issue_access('1);
		drain_table();

		// capacity zero acts as one; upper data bits are ignored
		apb_write(ADDR_ACTIVE, 32'hFFFF_FFE0);
		issue_access(32'h0000_0003);
		issue_access(32'h0000_0004);
		drain_table();

		// write past the register list is dropped, then oversize capacity
		apb_write(ADDR_UNMAPPED, 32'd1);
		issue_access(32'h0000_0005);
		drain_table();
		apb_write(ADDR_ACTIVE, 32'd31);
		for (int i = 0; i < 6; i++)
			issue_access(32'h1234_0000 + i);
		drain_table();

		// random phases over several capacities and idle levels
		for (int p = 0; p < RANDOM_PHASES; p++) begin
			apb_write(ADDR_ACTIVE, {27'd0, phase_caps[p]});
			eff_cap = (phase_caps[p] == 0) ? 1 :
				(phase_caps[p] > NUM_ENTRIES_DEF) ? NUM_ENTRIES_DEF : int'(phase_caps[p]);
			case (p % 3)
				0: idle_pct = 0;
				1: idle_pct = 61;
				default: idle_pct = 18;
			endcase

			// working set a little larger than the capacity; some keys one bit apart
			key_pool.delete();
			repeat (eff_cap + $urandom_range(1, 6)) begin
				if (key_pool.size() != 0 && $urandom_range(0, 7) == 0)
					key_pool.push_back(key_pool[$] ^ (32'd1 << $urandom_range(0, 31)));
				else
					key_pool.push_back($urandom);
			end

			for (int n = 0; n < PHASE_ITEMS; n++) begin
				if ($urandom_range(0, 99) < 15) begin
					key = $urandom;
				end else begin
					// skew toward the front of the pool so counts spread out
					pick = $urandom_range(0, key_pool.size() - 1);
					pick = (pick < 0) ? 0 : pick;
					if ($urandom_range(0, 1))
						pick = pick / 2;
					key = key_pool[pick];
				end
				if ($urandom_range(0, 99) < idle_pct) begin
					start <= 1'b0;
					repeat ($urandom_range(1, 24)) @(posedge clk);
				end
				issue_access(key);
				// sender holds off until the table has answered everything
				if (p == 4 && n % 25 == 24)
					drain_table();
			end
			drain_table();
		end

		repeat (2 * NUM_ENTRIES_DEF + 8) @(posedge clk);
		if (mismatch_count == 0)
			$display("tb: success");
		else
			$display("tb: failure");
		$finish;
	end

endmodule

@@ files.f @@
hw/rtl/lfu_pkg.sv
hw/rtl/lfu_ctrl.sv
hw/rtl/lfu_datapath.sv
hw/rtl/lfu_replacement_table.sv
verif/lfu_checker.sv
verif/tb_lfu_replacement_table.sv
